@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the operator token lexer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock and off while reset is active.
`define OTL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication, sampled on the rising clock and off during reset.
`define OTL_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

@@ src/otl_pkg.sv @@
// Package of the operator token lexer: token kinds, lexer state codes and shared types.
package otl_pkg;

  // Default width of the byte position counter.
  localparam int unsigned POSITION_BITS_DEF = 16;

  // Fixed widths of the token fields.
  localparam int unsigned KIND_BITS  = 5;
  localparam int unsigned START_BITS = 16;
  localparam int unsigned LEN_BITS   = 16;
  localparam int unsigned KW_BITS    = 4;

  // Longest run length that is counted; longer runs saturate here.
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  // Depth of the token queue in front of the output channel.
  localparam int unsigned FIFO_DEPTH = 4;

  // Token kinds in the order of the source language.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_OPEN_PAREN  = 5'd0,
    KIND_CLOSE_PAREN = 5'd1,
    KIND_QUESTION    = 5'd2,
    KIND_COLON       = 5'd3,
    KIND_EQ_EQ       = 5'd4,
    KIND_BANG_EQ     = 5'd5,
    KIND_BANG        = 5'd6,
    KIND_GT_GT_GT    = 5'd7,
    KIND_GT_GT       = 5'd8,
    KIND_GT_EQ       = 5'd9,
    KIND_GT          = 5'd10,
    KIND_LT_LT       = 5'd11,
    KIND_LT_EQ_GT    = 5'd12,
    KIND_LT_EQ       = 5'd13,
    KIND_LT          = 5'd14,
    KIND_AMP_AMP     = 5'd15,
    KIND_AMP         = 5'd16,
    KIND_CARET       = 5'd17,
    KIND_PIPE_PIPE   = 5'd18,
    KIND_PIPE        = 5'd19,
    KIND_TILDE       = 5'd20,
    KIND_PLUS        = 5'd21,
    KIND_MINUS       = 5'd22,
    KIND_STAR_STAR   = 5'd23,
    KIND_STAR        = 5'd24,
    KIND_SLASH_SLASH = 5'd25,
    KIND_SLASH       = 5'd26,
    KIND_PERCENT     = 5'd27,
    KIND_IDENT       = 5'd28,
    KIND_BOOL        = 5'd29,
    KIND_NUMBER      = 5'd30
  } kind_e;

  // Operator prefix held until the next byte decides the longest match.
  typedef enum logic [3:0] {
    PEND_NONE  = 4'd0,
    PEND_EQ    = 4'd1,
    PEND_BANG  = 4'd2,
    PEND_GT    = 4'd3,
    PEND_GTGT  = 4'd4,
    PEND_LT    = 4'd5,
    PEND_LTEQ  = 4'd6,
    PEND_AMP   = 4'd7,
    PEND_PIPE  = 4'd8,
    PEND_STAR  = 4'd9,
    PEND_SLASH = 4'd10
  } pend_e;

  // Kind of the run of bytes that is being collected.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2
  } mode_e;

  // Progress through the keywords true and false.
  localparam logic [KW_BITS-1:0] KW_START = 4'd0;
  localparam logic [KW_BITS-1:0] KW_T     = 4'd1;
  localparam logic [KW_BITS-1:0] KW_TR    = 4'd2;
  localparam logic [KW_BITS-1:0] KW_TRU   = 4'd3;
  localparam logic [KW_BITS-1:0] KW_TRUE  = 4'd4;
  localparam logic [KW_BITS-1:0] KW_F     = 4'd5;
  localparam logic [KW_BITS-1:0] KW_FA    = 4'd6;
  localparam logic [KW_BITS-1:0] KW_FAL   = 4'd7;
  localparam logic [KW_BITS-1:0] KW_FALS  = 4'd8;
  localparam logic [KW_BITS-1:0] KW_FALSE = 4'd9;
  localparam logic [KW_BITS-1:0] KW_FAIL  = 4'd15;

  // Lexer state apart from the position counters.
  typedef struct packed {
    pend_e               pend;
    mode_e               mode;
    logic [LEN_BITS-1:0] len;
    logic [KW_BITS-1:0]  kw;
  } run_state_t;

  // One token as it leaves the block.
  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [START_BITS-1:0] start;
    logic [LEN_BITS-1:0]   length;
    logic                  last;
  } token_t;

endpackage

@@ src/otl_if.sv @@
// Valid/ready channel interfaces for source bytes and for tokens.
interface otl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_source;

  modport source (output valid, output char_byte, output end_of_source, input ready);
  modport sink (input valid, input char_byte, input end_of_source, output ready);
endinterface

interface otl_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (
    output valid, output token_kind, output token_start, output token_length,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input token_start, input token_length,
    input last_of_run, output ready
  );
endinterface

@@ src/otl_decode.sv @@
// Per-byte lexer decision: next state and the up to two tokens one byte completes.
module otl_decode
  import otl_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic [7:0]               char_byte_i,
  input  logic                     end_of_source_i,
  input  logic [POSITION_BITS-1:0] pos_i,
  input  logic [POSITION_BITS-1:0] start_i,
  input  run_state_t               rs_i,
  output logic [POSITION_BITS-1:0] pos_o,
  output logic [POSITION_BITS-1:0] start_o,
  output run_state_t               rs_o,
  output token_t                   tok0_o,
  output token_t                   tok1_o,
  output logic [1:0]               tok_cnt_o
);

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // Next keyword match step for one more letter.
  function automatic logic [KW_BITS-1:0] kw_next(input logic [KW_BITS-1:0] s,
                                                 input logic [7:0] c);
    logic [KW_BITS-1:0] nxt;
    nxt = KW_FAIL;
    case (s)
      KW_START: begin
        if (c == "t") nxt = KW_T;
        else if (c == "f") nxt = KW_F;
      end
      KW_T:    if (c == "r") nxt = KW_TR;
      KW_TR:   if (c == "u") nxt = KW_TRU;
      KW_TRU:  if (c == "e") nxt = KW_TRUE;
      KW_F:    if (c == "a") nxt = KW_FA;
      KW_FA:   if (c == "l") nxt = KW_FAL;
      KW_FAL:  if (c == "s") nxt = KW_FALS;
      KW_FALS: if (c == "e") nxt = KW_FALSE;
      default: nxt = KW_FAIL;
    endcase
    return nxt;
  endfunction

  // Token of a pending operator that no longer extends; valid bit on top.
  function automatic logic [KIND_BITS:0] short_form(input pend_e p);
    logic [KIND_BITS:0] r;
    r = '0;
    case (p)
      PEND_BANG:  r = {1'b1, KIND_BANG};
      PEND_GT:    r = {1'b1, KIND_GT};
      PEND_GTGT:  r = {1'b1, KIND_GT_GT};
      PEND_LT:    r = {1'b1, KIND_LT};
      PEND_LTEQ:  r = {1'b1, KIND_LT_EQ};
      PEND_AMP:   r = {1'b1, KIND_AMP};
      PEND_PIPE:  r = {1'b1, KIND_PIPE};
      PEND_STAR:  r = {1'b1, KIND_STAR};
      PEND_SLASH: r = {1'b1, KIND_SLASH};
      default:    r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [LEN_BITS-1:0] short_len(input pend_e p);
    return ((p == PEND_GTGT) || (p == PEND_LTEQ)) ? 16'd2 : 16'd1;
  endfunction

  // Token that closes a letter or digit run; valid bit on top.
  function automatic logic [KIND_BITS:0] run_form(input run_state_t rs);
    logic [KIND_BITS:0] r;
    r = '0;
    case (rs.mode)
      MODE_WORD: begin
        if ((rs.kw == KW_TRUE) || (rs.kw == KW_FALSE)) r = {1'b1, KIND_BOOL};
        else r = {1'b1, KIND_IDENT};
      end
      MODE_NUM: r = {1'b1, KIND_NUMBER};
      default:  r = '0;
    endcase
    return r;
  endfunction

  token_t             cand [4];
  logic [3:0]         cand_vld;
  logic               used;
  logic               hit;
  kind_e              hit_kind;
  logic [LEN_BITS-1:0] hit_len;
  logic [KIND_BITS:0] form;
  logic [1:0]         n;
  logic [START_BITS-1:0] pos16;

  assign pos16 = START_BITS'(pos_i);

  always_comb begin
    rs_o     = rs_i;
    start_o  = start_i;
    used     = 1'b0;
    hit      = 1'b0;
    hit_kind = KIND_OPEN_PAREN;
    hit_len  = 16'd2;
    form     = '0;
    cand_vld = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end

    // Extend a pending operator, close a run, or neither.
    if (rs_i.pend != PEND_NONE) begin
      case (rs_i.pend)
        PEND_EQ:   if (char_byte_i == "=") begin hit = 1'b1; hit_kind = KIND_EQ_EQ; end
        PEND_BANG: if (char_byte_i == "=") begin hit = 1'b1; hit_kind = KIND_BANG_EQ; end
        PEND_GT: begin
          if (char_byte_i == ">") begin
            rs_o.pend = PEND_GTGT;
            used      = 1'b1;
          end else if (char_byte_i == "=") begin
            hit = 1'b1; hit_kind = KIND_GT_EQ;
          end
        end
        PEND_GTGT: if (char_byte_i == ">") begin
          hit = 1'b1; hit_kind = KIND_GT_GT_GT; hit_len = 16'd3;
        end
        PEND_LT: begin
          if (char_byte_i == "=") begin
            rs_o.pend = PEND_LTEQ;
            used      = 1'b1;
          end else if (char_byte_i == "<") begin
            hit = 1'b1; hit_kind = KIND_LT_LT;
          end
        end
        PEND_LTEQ: if (char_byte_i == ">") begin
          hit = 1'b1; hit_kind = KIND_LT_EQ_GT; hit_len = 16'd3;
        end
        PEND_AMP:   if (char_byte_i == "&") begin hit = 1'b1; hit_kind = KIND_AMP_AMP; end
        PEND_PIPE:  if (char_byte_i == "|") begin hit = 1'b1; hit_kind = KIND_PIPE_PIPE; end
        PEND_STAR:  if (char_byte_i == "*") begin hit = 1'b1; hit_kind = KIND_STAR_STAR; end
        PEND_SLASH: if (char_byte_i == "/") begin hit = 1'b1; hit_kind = KIND_SLASH_SLASH; end
        default: ;
      endcase
      if (hit) begin
        cand[0]     = '{kind: hit_kind, start: START_BITS'(start_i), length: hit_len,
                        last: 1'b0};
        cand_vld[0] = 1'b1;
        rs_o.pend   = PEND_NONE;
        used        = 1'b1;
      end else if (!used) begin
        form        = short_form(rs_i.pend);
        cand[0]     = '{kind: form[KIND_BITS-1:0], start: START_BITS'(start_i),
                        length: short_len(rs_i.pend), last: 1'b0};
        cand_vld[0] = form[KIND_BITS];
        rs_o.pend   = PEND_NONE;
      end
    end else if ((rs_i.mode == MODE_WORD) && is_letter(char_byte_i)) begin
      if (rs_i.len < LEN_MAX) begin
        rs_o.len = LEN_BITS'(rs_i.len + 16'd1);
        rs_o.kw  = kw_next(rs_i.kw, char_byte_i);
      end else begin
        rs_o.kw  = KW_FAIL;
      end
      used = 1'b1;
    end else if ((rs_i.mode == MODE_NUM) &&
                 (is_digit(char_byte_i) || (char_byte_i == "."))) begin
      if (rs_i.len < LEN_MAX) rs_o.len = LEN_BITS'(rs_i.len + 16'd1);
      used = 1'b1;
    end else if (rs_i.mode != MODE_IDLE) begin
      form        = run_form(rs_i);
      cand[0]     = '{kind: form[KIND_BITS-1:0], start: START_BITS'(start_i),
                      length: rs_i.len, last: 1'b0};
      cand_vld[0] = form[KIND_BITS];
      rs_o.mode   = MODE_IDLE;
      rs_o.len    = '0;
      rs_o.kw     = KW_START;
    end

    // A byte not taken by the state above starts a new token.
    if (!used) begin
      cand[1] = '{kind: KIND_OPEN_PAREN, start: pos16, length: 16'd1, last: 1'b0};
      case (char_byte_i)
        "(": begin cand_vld[1] = 1'b1; cand[1].kind = KIND_OPEN_PAREN; end
        ")": begin cand_vld[1] = 1'b1; cand[1].kind = KIND_CLOSE_PAREN; end
        "?": begin cand_vld[1] = 1'b1; cand[1].kind = KIND_QUESTION; end
        ":": begin cand_vld[1] = 1'b1; cand[1].kind = KIND_COLON; end
        "^": begin cand_vld[1] = 1'b1; cand[1].kind = KIND_CARET; end
        "~": begin cand_vld[1] = 1'b1; cand[1].kind = KIND_TILDE; end
        "+": begin cand_vld[1] = 1'b1; cand[1].kind = KIND_PLUS; end
        "-": begin cand_vld[1] = 1'b1; cand[1].kind = KIND_MINUS; end
        "%": begin cand_vld[1] = 1'b1; cand[1].kind = KIND_PERCENT; end
        "=": begin rs_o.pend = PEND_EQ;    start_o = pos_i; end
        "!": begin rs_o.pend = PEND_BANG;  start_o = pos_i; end
        ">": begin rs_o.pend = PEND_GT;    start_o = pos_i; end
        "<": begin rs_o.pend = PEND_LT;    start_o = pos_i; end
        "&": begin rs_o.pend = PEND_AMP;   start_o = pos_i; end
        "|": begin rs_o.pend = PEND_PIPE;  start_o = pos_i; end
        "*": begin rs_o.pend = PEND_STAR;  start_o = pos_i; end
        "/": begin rs_o.pend = PEND_SLASH; start_o = pos_i; end
        default: begin
          if (is_letter(char_byte_i)) begin
            rs_o.mode = MODE_WORD;
            start_o   = pos_i;
            rs_o.len  = 16'd1;
            rs_o.kw   = kw_next(KW_START, char_byte_i);
          end else if (is_digit(char_byte_i)) begin
            rs_o.mode = MODE_NUM;
            start_o   = pos_i;
            rs_o.len  = 16'd1;
            rs_o.kw   = KW_START;
          end
        end
      endcase
    end

    // End of source flushes whatever is still open and rewinds the position.
    if (end_of_source_i) begin
      form        = short_form(rs_o.pend);
      cand[2]     = '{kind: form[KIND_BITS-1:0], start: START_BITS'(start_o),
                      length: short_len(rs_o.pend), last: 1'b0};
      cand_vld[2] = form[KIND_BITS];
      form        = run_form(rs_o);
      cand[3]     = '{kind: form[KIND_BITS-1:0], start: START_BITS'(start_o),
                      length: rs_o.len, last: 1'b0};
      cand_vld[3] = form[KIND_BITS];
      rs_o.pend   = PEND_NONE;
      rs_o.mode   = MODE_IDLE;
      rs_o.len    = '0;
      rs_o.kw     = KW_START;
      pos_o       = '0;
    end else begin
      pos_o = pos_i + {{(POSITION_BITS-1){1'b0}}, 1'b1};
    end
  end

  // Keep the first two tokens in order and mark the final one.
  always_comb begin
    n      = 2'd0;
    tok0_o = '0;
    tok1_o = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_vld[i]) begin
        if (n == 2'd0) begin
          tok0_o = cand[i];
          n      = 2'd1;
        end else if (n == 2'd1) begin
          tok1_o = cand[i];
          n      = 2'd2;
        end
      end
    end
    tok0_o.last = (n == 2'd1);
    tok1_o.last = 1'b1;
    tok_cnt_o   = n;
  end

endmodule

@@ src/operator_token_lexer.sv @@
// A token is written into the token queue when the byte beat that completes it is taken,
// and is offered from the head of that queue. One byte beat per cycle is taken while at most
// one token per byte is produced and the token sink keeps up; a byte that completes two tokens
// is buffered in a four-token queue that takes a byte whenever it holds two tokens or fewer.
// Reset clears the byte position, the pending operator, the open run and the token queue.
module operator_token_lexer
  import otl_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  otl_byte_if.sink    byte_i,
  otl_token_if.source tok_o
);

  localparam int unsigned PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] ROOM_LIMIT = CNT_BITS'(FIFO_DEPTH - 2);

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  run_state_t               rs_q, rs_d;
  token_t                   tok0, tok1;
  logic [1:0]               tok_cnt;

  token_t                   fifo_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0]      wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [CNT_BITS-1:0]      cnt_q;
  logic                     push, pop;
  logic [1:0]               push_cnt;

  // Per-byte decision logic.
  otl_decode #(
    .POSITION_BITS(POSITION_BITS)
  ) u_decode (
    .char_byte_i    (byte_i.char_byte),
    .end_of_source_i(byte_i.end_of_source),
    .pos_i          (pos_q),
    .start_i        (start_q),
    .rs_i           (rs_q),
    .pos_o          (pos_d),
    .start_o        (start_d),
    .rs_o           (rs_d),
    .tok0_o         (tok0),
    .tok1_o         (tok1),
    .tok_cnt_o      (tok_cnt)
  );

  // A byte beat is taken while the queue has room for two tokens.
  assign byte_i.ready = (cnt_q <= ROOM_LIMIT);
  assign push         = byte_i.valid && byte_i.ready;
  assign push_cnt     = push ? tok_cnt : 2'd0;
  assign pop          = tok_o.valid && tok_o.ready;
  assign wr_ptr_nx    = wr_ptr_q + {{(PTR_BITS-1){1'b0}}, 1'b1};

  // Lexer state advances on every accepted byte beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= '0;
      rs_q    <= '{pend: PEND_NONE, mode: MODE_IDLE, len: '0, kw: KW_START};
    end else if (push) begin
      pos_q   <= pos_d;
      start_q <= start_d;
      rs_q    <= rs_d;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= PTR_BITS'(wr_ptr_q + PTR_BITS'(push_cnt));
      rd_ptr_q <= PTR_BITS'(rd_ptr_q + PTR_BITS'(pop));
      cnt_q    <= CNT_BITS'(cnt_q + CNT_BITS'(push_cnt) - CNT_BITS'(pop));
    end
  end

  // Queue storage: one or two tokens written per byte beat.
  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) fifo_q[wr_ptr_q]  <= tok0;
    if (push_cnt == 2'd2) fifo_q[wr_ptr_nx] <= tok1;
  end

  // Head of the queue drives the token channel.
  assign tok_o.valid        = (cnt_q != '0);
  assign tok_o.token_kind   = fifo_q[rd_ptr_q].kind;
  assign tok_o.token_start  = fifo_q[rd_ptr_q].start;
  assign tok_o.token_length = fifo_q[rd_ptr_q].length;
  assign tok_o.last_of_run  = fifo_q[rd_ptr_q].last;

endmodule

@@ src/otl_checker.sv @@
// Port-level assertions for the operator token lexer and the bind that attaches them.
`include "assert_macros.svh"

module otl_checker
  import otl_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  token_kind_i,
  input logic [15:0] token_start_i,
  input logic [15:0] token_length_i,
  input logic        last_of_run_i
);

  // A stalled token beat keeps its contents.
  `OTL_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable({token_kind_i, token_start_i, token_length_i, last_of_run_i})), "token beat changed while stalled")

  // Every token spans at least one byte.
  `OTL_ASSERT_IMPLY(a_len_nonzero, clk_i, rst_ni, out_valid_i, token_length_i != 16'd0, "token of zero length")

  // Kind codes stop at the number literal.
  `OTL_ASSERT_IMPLY(a_kind_range, clk_i, rst_ni, out_valid_i, token_kind_i <= KIND_NUMBER, "token kind out of range")

  // Tokens appear only after a byte beat was taken.
  `OTL_ASSERT(a_no_phantom, clk_i, rst_ni, (out_valid_i && !$past(out_valid_i)) |-> $past(in_valid_i && in_ready_i), "token appeared without a byte beat")

endmodule

bind operator_token_lexer otl_checker u_otl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (byte_i.valid),
  .in_ready_i    (byte_i.ready),
  .out_valid_i   (tok_o.valid),
  .out_ready_i   (tok_o.ready),
  .token_kind_i  (tok_o.token_kind),
  .token_start_i (tok_o.token_start),
  .token_length_i(tok_o.token_length),
  .last_of_run_i (tok_o.last_of_run)
);

@@ tb/tb.sv @@
// Self-checking testbench of the operator token lexer: byte driver, token monitor and predictor.
module tb
  import otl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One source byte as it waits in the driver queue.
  typedef struct packed {
    logic [7:0] c;
    logic       eos;
  } source_byte_t;

  // Shapes of backpressure that the token sink applies.
  typedef enum int {
    SINK_ALWAYS   = 0,
    SINK_RANDOM   = 1,
    SINK_PERIODIC = 2
  } sink_mode_e;

  localparam int unsigned RANDOM_BYTES = 560;
  localparam int unsigned DRAIN_CYCLES = 5000;
  localparam int unsigned MAX_REPORTS  = 50;

  logic clk_i = 1'b0;
  logic rst_ni;

  otl_byte_if  byte_bus ();
  otl_token_if tok_bus ();

  operator_token_lexer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_bus),
    .tok_o  (tok_bus)
  );

  always #10 clk_i = ~clk_i;

  // Every operator spelling, plus the lone equal sign that yields nothing.
  string op_spellings [29] = '{
    "(", ")", "?", ":", "==", "!=", "!", ">>>", ">>", ">=", ">", "<<", "<=>", "<=", "<",
    "&&", "&", "^", "||", "|", "~", "+", "-", "**", "*", "//", "/", "%", "="
  };

  source_byte_t source_bytes [$];
  token_t       tokens_due [$];
  token_t       step_tokens [$];
  int unsigned  errors = 0;
  bit           byte_fire = 1'b0;

  // Predicted lexer state.
  logic [15:0] lex_pos   = '0;
  logic [15:0] lex_start = '0;
  logic [15:0] lex_len   = '0;
  pend_e       lex_pend  = PEND_NONE;
  mode_e       lex_mode  = MODE_IDLE;
  logic [3:0]  lex_kw    = KW_START;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Next step of the keyword matcher for true and false.
  function automatic logic [3:0] keyword_next(logic [3:0] s, logic [7:0] c);
    case (s)
      KW_START: return (c == "t") ? KW_T : ((c == "f") ? KW_F : KW_FAIL);
      KW_T:     return (c == "r") ? KW_TR : KW_FAIL;
      KW_TR:    return (c == "u") ? KW_TRU : KW_FAIL;
      KW_TRU:   return (c == "e") ? KW_TRUE : KW_FAIL;
      KW_F:     return (c == "a") ? KW_FA : KW_FAIL;
      KW_FA:    return (c == "l") ? KW_FAL : KW_FAIL;
      KW_FAL:   return (c == "s") ? KW_FALS : KW_FAIL;
      KW_FALS:  return (c == "e") ? KW_FALSE : KW_FAIL;
      default:  return KW_FAIL;
    endcase
  endfunction

  // A single byte never completes more than two tokens.
  function automatic void add_token(kind_e k, logic [15:0] s, logic [15:0] l);
    if (step_tokens.size() < 2) begin
      step_tokens.push_back('{kind: k, start: s, length: l, last: 1'b0});
    end
  endfunction

  // Emit a held operator prefix as its shorter form.
  function automatic void flush_operator();
    case (lex_pend)
      PEND_BANG:  add_token(KIND_BANG, lex_start, 16'd1);
      PEND_GT:    add_token(KIND_GT, lex_start, 16'd1);
      PEND_GTGT:  add_token(KIND_GT_GT, lex_start, 16'd2);
      PEND_LT:    add_token(KIND_LT, lex_start, 16'd1);
      PEND_LTEQ:  add_token(KIND_LT_EQ, lex_start, 16'd2);
      PEND_AMP:   add_token(KIND_AMP, lex_start, 16'd1);
      PEND_PIPE:  add_token(KIND_PIPE, lex_start, 16'd1);
      PEND_STAR:  add_token(KIND_STAR, lex_start, 16'd1);
      PEND_SLASH: add_token(KIND_SLASH, lex_start, 16'd1);
      default: ;
    endcase
    lex_pend = PEND_NONE;
  endfunction

  // Close an open word or number run.
  function automatic void flush_run();
    if (lex_mode == MODE_WORD) begin
      if (lex_kw == KW_TRUE || lex_kw == KW_FALSE) begin
        add_token(KIND_BOOL, lex_start, lex_len);
      end else begin
        add_token(KIND_IDENT, lex_start, lex_len);
      end
    end else if (lex_mode == MODE_NUM) begin
      add_token(KIND_NUMBER, lex_start, lex_len);
    end
    lex_mode = MODE_IDLE;
    lex_len  = '0;
    lex_kw   = KW_START;
  endfunction

  // Try to grow the held prefix with c; returns 1 when c was consumed.
  function automatic bit extend_operator(logic [7:0] c);
    kind_e       k;
    logic [15:0] l;
    bit          hit;
    k   = KIND_EQ_EQ;
    l   = 16'd2;
    hit = 1'b0;
    if (lex_pend == PEND_GT && c == ">") begin
      lex_pend = PEND_GTGT;
      return 1'b1;
    end
    if (lex_pend == PEND_LT && c == "=") begin
      lex_pend = PEND_LTEQ;
      return 1'b1;
    end
    case (lex_pend)
      PEND_EQ: begin
        hit = (c == "="); k = KIND_EQ_EQ;
      end
      PEND_BANG: begin
        hit = (c == "="); k = KIND_BANG_EQ;
      end
      PEND_GT: begin
        hit = (c == "="); k = KIND_GT_EQ;
      end
      PEND_GTGT: begin
        hit = (c == ">"); k = KIND_GT_GT_GT; l = 16'd3;
      end
      PEND_LT: begin
        hit = (c == "<"); k = KIND_LT_LT;
      end
      PEND_LTEQ: begin
        hit = (c == ">"); k = KIND_LT_EQ_GT; l = 16'd3;
      end
      PEND_AMP: begin
        hit = (c == "&"); k = KIND_AMP_AMP;
      end
      PEND_PIPE: begin
        hit = (c == "|"); k = KIND_PIPE_PIPE;
      end
      PEND_STAR: begin
        hit = (c == "*"); k = KIND_STAR_STAR;
      end
      PEND_SLASH: begin
        hit = (c == "/"); k = KIND_SLASH_SLASH;
      end
      default: hit = 1'b0;
    endcase
    if (hit) begin
      add_token(k, lex_start, l);
      lex_pend = PEND_NONE;
      return 1'b1;
    end
    flush_operator();
    return 1'b0;
  endfunction

  // Start whatever token c opens at position p; other bytes are skipped.
  function automatic void start_token(logic [7:0] c, logic [15:0] p);
    pend_e held;
    held = PEND_NONE;
    case (c)
      "(": add_token(KIND_OPEN_PAREN, p, 16'd1);
      ")": add_token(KIND_CLOSE_PAREN, p, 16'd1);
      "?": add_token(KIND_QUESTION, p, 16'd1);
      ":": add_token(KIND_COLON, p, 16'd1);
      "^": add_token(KIND_CARET, p, 16'd1);
      "~": add_token(KIND_TILDE, p, 16'd1);
      "+": add_token(KIND_PLUS, p, 16'd1);
      "-": add_token(KIND_MINUS, p, 16'd1);
      "%": add_token(KIND_PERCENT, p, 16'd1);
      "=": held = PEND_EQ;
      "!": held = PEND_BANG;
      ">": held = PEND_GT;
      "<": held = PEND_LT;
      "&": held = PEND_AMP;
      "|": held = PEND_PIPE;
      "*": held = PEND_STAR;
      "/": held = PEND_SLASH;
      default: begin
        if (is_letter(c)) begin
          lex_mode  = MODE_WORD;
          lex_start = p;
          lex_len   = 16'd1;
          lex_kw    = keyword_next(KW_START, c);
        end else if (is_digit(c)) begin
          lex_mode  = MODE_NUM;
          lex_start = p;
          lex_len   = 16'd1;
          lex_kw    = KW_START;
        end
      end
    endcase
    if (held != PEND_NONE) begin
      lex_pend  = held;
      lex_start = p;
    end
  endfunction

  // Advance the predicted lexer by one accepted byte and queue the tokens it completes.
  function automatic void lex_byte(logic [7:0] c, logic eos);
    logic [15:0] p;
    bit          used;
    step_tokens.delete();
    p    = lex_pos;
    used = 1'b0;
    if (lex_pend != PEND_NONE) begin
      used = extend_operator(c);
    end else if (lex_mode == MODE_WORD && is_letter(c)) begin
      if (lex_len != LEN_MAX) begin
        lex_len = lex_len + 16'd1;
        lex_kw  = keyword_next(lex_kw, c);
      end else begin
        lex_kw = KW_FAIL;
      end
      used = 1'b1;
    end else if (lex_mode == MODE_NUM && (is_digit(c) || c == ".")) begin
      if (lex_len != LEN_MAX) lex_len = lex_len + 16'd1;
      used = 1'b1;
    end else if (lex_mode != MODE_IDLE) begin
      flush_run();
    end
    if (!used) start_token(c, p);
    if (eos) begin
      flush_operator();
      flush_run();
      lex_pos = '0;
    end else begin
      lex_pos = p + 16'd1;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
  endfunction

  function automatic void push_byte(logic [7:0] c, logic eos);
    source_bytes.push_back('{c: c, eos: eos});
  endfunction

  // Queue a string, marking its final byte as the end of a source when eos is set.
  function automatic void push_text(string s, logic eos);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], eos && (i == s.len() - 1));
    end
  endfunction

  function automatic logic [7:0] random_letter();
    if ($urandom_range(0, 1) == 0) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  // Random source text built from token-shaped fragments with some noise mixed in.
  function automatic void build_random_source();
    int unsigned counted;
    int unsigned pick;
    int unsigned n;
    logic        eos;
    logic [7:0]  c;
    counted = 0;
    while (counted < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      eos  = ($urandom_range(0, 9) == 0);
      if (pick < 35) begin
        push_text(op_spellings[$urandom_range(0, 28)], eos);
        counted += 2;
      end else if (pick < 55) begin
        case ($urandom_range(0, 7))
          0: push_text("true", eos);
          1: push_text("false", eos);
          2: push_text("tru", eos);
          3: push_text("falsey", eos);
          default: begin
            n = $urandom_range(1, 7);
            for (int i = 0; i < n; i++) push_byte(random_letter(), eos && (i == n - 1));
          end
        endcase
        counted += 4;
      end else if (pick < 70) begin
        n = $urandom_range(0, 5);
        push_byte(8'("0" + $urandom_range(0, 9)), eos && (n == 0));
        for (int i = 0; i < n; i++) begin
          c = ($urandom_range(0, 3) == 0) ? 8'(".") : 8'("0" + $urandom_range(0, 9));
          push_byte(c, eos && (i == n - 1));
        end
        counted += n + 1;
      end else if (pick < 82) begin
        case ($urandom_range(0, 2))
          0: push_byte(" ", eos);
          1: push_byte("\t", eos);
          default: push_byte("\n", eos);
        endcase
      end else begin
        push_byte(8'($urandom_range(0, 255)), eos);
        counted += 1;
      end
    end
    push_text(" ", 1'b1);
  endfunction

  // Byte driver: bursts of beats separated by random gaps, changing on the falling edge.
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin : byte_driver
    source_byte_t item;
    if (!rst_ni) begin
      byte_bus.valid         <= 1'b0;
      byte_bus.char_byte     <= '0;
      byte_bus.end_of_source <= 1'b0;
    end else if (!byte_bus.valid || byte_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        byte_bus.valid <= 1'b0;
      end else if (source_bytes.size() > 0) begin
        item = source_bytes.pop_front();
        byte_bus.valid         <= 1'b1;
        byte_bus.char_byte     <= item.c;
        byte_bus.end_of_source <= item.eos;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        byte_bus.valid <= 1'b0;
      end
    end
  end

  // Token sink: ready follows a mode that is picked anew at random whenever its run ends.
  sink_mode_e  sink_mode   = SINK_ALWAYS;
  int unsigned sink_left   = 0;
  int unsigned sink_tick   = 0;

  always @(negedge clk_i) begin : token_sink
    logic rdy;
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 2));
      sink_left = $urandom_range(64, 256);
    end
    sink_left--;
    sink_tick++;
    case (sink_mode)
      SINK_ALWAYS: rdy = 1'b1;
      SINK_RANDOM: rdy = 1'($urandom_range(0, 1));
      default:     rdy = (sink_tick % 8) >= 3;
    endcase
    if (rst_ni) begin
      tok_bus.ready <= rdy;
    end else begin
      tok_bus.ready <= 1'b0;
    end
  end

  // Monitor: check token beats against predictions, then predict from the byte beat.
  always @(posedge clk_i) begin : beat_monitor
    token_t want;
    if (rst_ni) begin
      if (tok_bus.valid && tok_bus.ready) begin
        if (tokens_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: unexpected token, expected none,", $time,
                     " got kind %0d start %0d length %0d last %0d",
                     tok_bus.token_kind, tok_bus.token_start, tok_bus.token_length,
                     tok_bus.last_of_run);
          end
        end else begin
          want = tokens_due.pop_front();
          if (tok_bus.token_kind !== want.kind || tok_bus.token_start !== want.start ||
              tok_bus.token_length !== want.length || tok_bus.last_of_run !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: token mismatch,", $time,
                       " expected kind %0d start %0d length %0d last %0d,",
                       want.kind, want.start, want.length, want.last,
                       " got kind %0d start %0d length %0d last %0d",
                       tok_bus.token_kind, tok_bus.token_start, tok_bus.token_length,
                       tok_bus.last_of_run);
            end
          end
        end
      end
      byte_fire = byte_bus.valid && byte_bus.ready;
      if (byte_fire) lex_byte(byte_bus.char_byte, byte_bus.end_of_source);
    end else begin
      byte_fire = 1'b0;
    end
  end

  // Reset, stimulus and end of run.
  initial begin : main
    int unsigned waited;
    rst_ni = 1'b0;

    // Directed part: every operator, keywords, number shape, byte extremes, flushes.
    push_text("(?:)^~+-%", 1'b1);
    push_text(">=>>>==!=!<=><<&&&|||**///", 1'b1);
    push_text(">>", 1'b1);
    push_text("<=", 1'b1);
    push_text("<*> =", 1'b1);
    push_text("true false trues fals AZz 09.1.", 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_text("x", 1'b1);
    push_text("=", 1'b1);

    build_random_source();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (source_bytes.size() != 0 || byte_bus.valid) @(posedge clk_i);
    waited = 0;
    while (tokens_due.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);

    if (tokens_due.size() != 0) begin
      $display("%0t: %0d tokens never arrived,", $time, tokens_due.size(),
               " expected kind %0d start %0d length %0d, got none",
               tokens_due[0].kind, tokens_due[0].start, tokens_due[0].length);
    end
    if (errors == 0 && tokens_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #200ms;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/otl_pkg.sv
src/otl_if.sv
src/otl_decode.sv
src/operator_token_lexer.sv
src/otl_checker.sv
tb/tb.sv
